// ===== rtl/core/rlm_pkg.sv =====
package rlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int RMS_W    = 32;
    localparam int ALPHA_W  = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd26214;
    // 20*log10(2) in Q16
    localparam logic [31:0] DB_PER_OCT = 32'd394566;
    // -120 dB in Q8.8, as a magnitude
    localparam logic [15:0] DB_FLOOR = 16'd30720;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_ACC  = 4'd0;
    localparam logic [ST_W-1:0] ST_DIV  = 4'd1;
    localparam logic [ST_W-1:0] ST_SQRT = 4'd2;
    localparam logic [ST_W-1:0] ST_MUL1 = 4'd3;
    localparam logic [ST_W-1:0] ST_MUL2 = 4'd4;
    localparam logic [ST_W-1:0] ST_NORM = 4'd5;
    localparam logic [ST_W-1:0] ST_LOG  = 4'd6;
    localparam logic [ST_W-1:0] ST_DB   = 4'd7;
    localparam logic [ST_W-1:0] ST_FIN  = 4'd8;

endpackage

// ===== rtl/core/rlm_in_if.sv =====
interface rlm_in_if
    import rlm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

// ===== rtl/core/rlm_out_if.sv =====
interface rlm_out_if
    import rlm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_db;
    logic        [RMS_W-1:0]   rms_smoothed;

    modport source (output valid, output level_db, output rms_smoothed, input ready);
    modport sink   (input valid, input level_db, input rms_smoothed, output ready);
endinterface

// ===== rtl/core/rms_level_meter_db_top.sv =====
// RMS level meter with smoothing and dBFS readout.
// samples: valid/ready channel of signed 16-bit samples; block_end marks the
//   last sample of a block. While a block is open one sample transfers per
//   cycle; samples beyond MAX_BLOCK are dropped but block_end still closes it.
// levels: one result per block: smoothed RMS (unsigned Q16.16) and level in
//   dBFS (signed Q8.8, floored at -120 dB).
// cfg_we/cfg_wdata: writes smooth_alpha (Q0.16 weight of the previous RMS).
// After the block_end transfer the block is busy in the bit-serial divide, the
//   bit-serial square root, the two smoothing multiplies, normalization, the
//   log steps, the dB scaling and the finish; the smoothing, log and dB steps
//   share the one multiplier. samples.ready is low meanwhile.
// The result sits in an output register; if levels stalls, the next block is
//   still accepted and only its finish waits for the register to free.
// Reset clears the sums, the smoothed RMS and loads alpha with its default.
module rms_level_meter_db_top
    import rlm_pkg::*;
#(
    parameter int MAX_BLOCK = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    rlm_in_if.sink             samples,
    rlm_out_if.source          levels,
    input  logic               cfg_we,
    input  logic [ALPHA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = 30 + CNT_W;
    localparam int DIV_W = SUM_W + 32;
    localparam int IT_W  = $clog2(DIV_W + 1);

    logic [ST_W-1:0]    state_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        smooth_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [IT_W-1:0]    it_reg;
    logic [63:0]        v_reg;
    logic [63:0]        res_reg;
    logic [31:0]        rms_reg;
    logic [48:0]        acc_reg;
    logic [31:0]        norm_reg;
    logic [4:0]         sh_reg;
    logic [30:0]        m_reg;
    logic [15:0]        frac_reg;
    logic [15:0]        mag_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [RMS_W-1:0]   out_rms_reg;

    // accumulation
    logic [15:0]      mag;
    logic [31:0]      sq;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_next;
    logic             take;

    assign mag  = samples.sample[15] ? 16'(-samples.sample) : 16'(samples.sample);
    assign sq   = {16'b0, mag} * {16'b0, mag};
    assign take = samples.valid && samples.ready;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (count_reg < CNT_W'(MAX_BLOCK))
        begin
            sum_next   = sum_reg + SUM_W'(sq);
            count_next = count_reg + CNT_W'(1);
        end
    end

    // divider step
    logic [CNT_W:0] rem_sh;
    logic           q_bit;
    logic [CNT_W:0] rem_diff;
    assign rem_sh   = {rem_reg, div_reg[DIV_W-1]};
    assign q_bit    = rem_sh >= {1'b0, count_reg};
    assign rem_diff = rem_sh - {1'b0, count_reg};

    // root step
    logic [63:0] bitv;
    logic [63:0] trial;
    assign bitv  = 64'(1) << {it_reg[4:0], 1'b0};
    assign trial = res_reg + bitv;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [20:0] d_oct;

    assign d_oct = {sh_reg, 16'b0} - {5'b0, frac_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = smooth_reg;
                mul_b = {16'b0, alpha_reg};
            end
            ST_MUL2:
            begin
                mul_a = rms_reg;
                mul_b = 32'(17'h10000 - {1'b0, alpha_reg});
            end
            ST_LOG:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_DB:
            begin
                mul_a = {11'b0, d_oct};
                mul_b = DB_PER_OCT;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    logic [48:0] acc_sum;
    logic [31:0] smooth_new;
    logic [31:0] log_sq;
    logic [41:0] db_rnd;
    logic [17:0] db_mag;

    assign acc_sum    = acc_reg + prod[48:0];
    assign smooth_new = acc_sum[47:16];
    assign log_sq     = prod[61:30];
    assign db_rnd     = prod[41:0] + 42'd8388608;
    assign db_mag     = db_rnd[41:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            alpha_reg     <= ALPHA_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            smooth_reg    <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                alpha_reg <= cfg_wdata;
            // in ST_FIN the output register is handled below
            if (levels.valid && levels.ready && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_ACC:
                begin
                    if (take)
                    begin
                        count_reg <= count_next;
                        if (samples.block_end)
                        begin
                            sum_reg   <= '0;
                            div_reg   <= {sum_next, 32'b0};
                            rem_reg   <= '0;
                            it_reg    <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                            sum_reg <= sum_next;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    div_reg <= {div_reg[DIV_W-2:0], q_bit};
                    if (it_reg == IT_W'(DIV_W - 1))
                    begin
                        it_reg    <= IT_W'(31);
                        state_reg <= ST_SQRT;
                    end
                    else
                        it_reg <= it_reg + IT_W'(1);
                end
                ST_SQRT:
                begin
                    // first step: quotient is complete in div_reg
                    if (it_reg == IT_W'(31) && res_reg != 64'hFFFF_FFFF_FFFF_FFFF)
                    begin
                        res_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
                        v_reg   <= div_reg[63:0];
                    end
                    else
                    begin
                        if (v_reg >= (it_reg == IT_W'(31) ? bitv : trial))
                        begin
                            v_reg   <= v_reg - (it_reg == IT_W'(31) ? bitv : trial);
                            res_reg <= ((it_reg == IT_W'(31) ? 64'd0 : res_reg) >> 1) + bitv;
                        end
                        else
                            res_reg <= (it_reg == IT_W'(31) ? 64'd0 : res_reg) >> 1;
                        if (it_reg == '0)
                            state_reg <= ST_MUL1;
                        else
                            it_reg <= it_reg - IT_W'(1);
                    end
                end
                ST_MUL1:
                begin
                    rms_reg   <= res_reg[31:0];
                    acc_reg   <= prod[48:0] + 49'd32768;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    smooth_reg <= smooth_new;
                    norm_reg   <= smooth_new;
                    sh_reg     <= '0;
                    if (smooth_new == '0)
                    begin
                        mag_reg   <= DB_FLOOR;
                        state_reg <= ST_FIN;
                    end
                    else
                        state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (norm_reg[31])
                    begin
                        m_reg     <= norm_reg[31:1];
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_LOG;
                    end
                    else
                    begin
                        norm_reg <= norm_reg << 1;
                        sh_reg   <= sh_reg + 5'd1;
                    end
                end
                ST_LOG:
                begin
                    frac_reg <= {frac_reg[14:0], log_sq[31]};
                    m_reg    <= log_sq[31] ? log_sq[31:1] : log_sq[30:0];
                    if (it_reg == IT_W'(15))
                        state_reg <= ST_DB;
                    else
                        it_reg <= it_reg + IT_W'(1);
                end
                ST_DB:
                begin
                    mag_reg   <= (db_mag > {2'b0, DB_FLOOR}) ? DB_FLOOR : db_mag[15:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || levels.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= 16'(17'h10000 - {1'b0, mag_reg});
                        out_rms_reg   <= smooth_reg;
                        count_reg     <= '0;
                        res_reg       <= '0;
                        state_reg     <= ST_ACC;
                    end
                end
                default:
                    state_reg <= ST_ACC;
            endcase
        end
    end

    assign samples.ready       = (state_reg == ST_ACC);
    assign levels.valid        = out_valid_reg;
    assign levels.level_db     = out_level_reg;
    assign levels.rms_smoothed = out_rms_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCK))
        else $error("sample count above block limit");

    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && samples.block_end) |=> !samples.ready)
        else $error("input still ready after block end");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        levels.valid |-> (levels.level_db <= 16'sd0 && levels.level_db >= -16'sd30720))
        else $error("level out of range");

    a_zero_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (levels.valid && levels.rms_smoothed == '0) |-> levels.level_db == -16'sd30720)
        else $error("zero rms not at floor");

    a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
        levels.valid |-> levels.rms_smoothed <= 32'h8000_0000)
        else $error("rms above full scale");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rlm_pkg::*;

    localparam int MAX_BLOCK   = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 250;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_db;
        logic [RMS_W-1:0]          rms_smoothed;
    } level_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ALPHA_W-1:0] cfg_wdata = '0;

    rlm_in_if  samples();
    rlm_out_if levels();

    rms_level_meter_db_top #(.MAX_BLOCK(MAX_BLOCK)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .levels   (levels),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [63:0] sq_acc;
    int unsigned blk_cnt;
    logic [31:0] smooth_q16;
    logic [ALPHA_W-1:0] alpha_w;

    level_t level_q[$];
    int errors = 0;
    int n_samples = 0;
    int n_blocks = 0;
    int n_checked = 0;
    int cycles = 0;
    int in_idle = 0;
    int out_stall = 0;
    int hold_left = 0;

    function automatic logic [31:0] root64(logic [63:0] v);
        logic [31:0] res;
        logic [31:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = res | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v)
                res = trial;
        end
        return res;
    endfunction

    function automatic logic [31:0] log2_fix(logic [31:0] s);
        int p;
        logic [63:0] m;
        logic [15:0] frac;
        p = 31;
        frac = '0;
        while (s[p] == 1'b0)
            p--;
        if (p >= 30)
            m = 64'(s >> (p - 30));
        else
            m = 64'(s) << (30 - p);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (32'(p) << 16) | 32'(frac);
    endfunction

    // update meter state for one accepted sample; returns 1 with a level at block end
    function automatic bit meter_step(logic signed [15:0] s, logic last, output level_t lv);
        logic [63:0] mag;
        logic [63:0] mean;
        logic [63:0] acc;
        logic [63:0] d;
        logic [63:0] dm;
        logic [31:0] rms;
        logic [15:0] lmag;
        mag = (s < 0) ? 64'(-32'(s)) : 64'(s);
        lv = '0;
        if (blk_cnt < MAX_BLOCK)
        begin
            sq_acc += mag * mag;
            blk_cnt++;
        end
        if (!last)
            return 0;
        mean = ((sq_acc / blk_cnt) << 32) + (((sq_acc % blk_cnt) << 32) / blk_cnt);
        rms = root64(mean);
        acc = 64'(smooth_q16) * 64'(alpha_w) + 64'(rms) * (64'd65536 - 64'(alpha_w))
            + 64'd32768;
        smooth_q16 = acc[47:16];
        if (smooth_q16 == 0)
            lmag = DB_FLOOR;
        else
        begin
            d = (64'd31 << 16) - 64'(log2_fix(smooth_q16));
            dm = (d * 64'(DB_PER_OCT) + (64'd1 << 23)) >> 24;
            lmag = (dm > 64'(DB_FLOOR)) ? DB_FLOOR : dm[15:0];
        end
        lv.level_db = -$signed(lmag);
        lv.rms_smoothed = smooth_q16;
        sq_acc = '0;
        blk_cnt = 0;
        return 1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (block %0d)", what, got, want, n_checked);
    endtask

    // result checker
    always @(posedge clk)
    begin
        level_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
        if (rst_n && levels.valid && levels.ready)
        begin
            if (level_q.size() == 0)
                report("unexpected level", 32'(levels.level_db), 32'd0);
            else
            begin
                want = level_q.pop_front();
                if (levels.level_db !== want.level_db)
                    report("level_db", 32'(levels.level_db), 32'(want.level_db));
                if (levels.rms_smoothed !== want.rms_smoothed)
                    report("rms_smoothed", levels.rms_smoothed, want.rms_smoothed);
                n_checked++;
            end
        end
    end

    // receiver stall; a hold-off forces a long stretch of back-pressure
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            levels.ready <= 1'b0;
            hold_left--;
        end
        else
            levels.ready <= ($urandom_range(99) >= out_stall);
    end

    task automatic send_sample(logic signed [15:0] s, logic last);
        level_t lv;
        while ($urandom_range(99) < in_idle)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid     <= 1'b1;
        samples.sample    <= s;
        samples.block_end <= last;
        do
            @(posedge clk);
        while (!samples.ready);
        n_samples++;
        if (meter_step(s, last, lv))
        begin
            level_q.push_back(lv);
            n_blocks++;
        end
        @(negedge clk);
    endtask

    task automatic idle_input();
        samples.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        logic signed [15:0] s;
        s = 16'($urandom);
        return s >>> $urandom_range(15);
    endfunction

    task automatic send_block(int len);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), i == len - 1);
    endtask

    task automatic drain();
        idle_input();
        while (level_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_alpha(logic [ALPHA_W-1:0] a);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we    <= 1'b0;
        alpha_w = a;
        @(negedge clk);
    endtask

    task automatic test_directed();
        // all-zero block right after reset: floor level
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b1);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 16'sh7fff : 16'sh8000, i == 5);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shaaaa, 1'b1);
        drain();
    endtask

    task automatic test_alpha_extremes();
        write_alpha(16'd0);
        send_sample(16'sd1000, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        drain();
        write_alpha(16'hffff);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd0, 1'b1);
        drain();
        write_alpha(ALPHA_RESET);
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int sent;
        int len;
        in_idle = idle_pct;
        out_stall = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(99) < 3) ? $urandom_range(64, 300) : $urandom_range(1, 12);
            send_block(len);
            sent += len;
        end
        drain();
        in_idle = 0;
        out_stall = 0;
    endtask

    task automatic test_backpressure();
        hold_left = 600;
        for (int i = 0; i < 8; i++)
            send_block($urandom_range(1, 4));
        drain();
    endtask

    initial
    begin
        sq_acc = '0;
        blk_cnt = 0;
        smooth_q16 = '0;
        alpha_w = ALPHA_RESET;
        samples.valid = 1'b0;
        samples.sample = '0;
        samples.block_end = 1'b0;
        levels.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_alpha_extremes();
        test_random(200, 0, 0);
        test_backpressure();
        write_alpha(16'($urandom));
        test_random(200, 79, 0);
        write_alpha(16'hffff);
        test_random(150, 0, 79);
        write_alpha(16'd0);
        test_random(150, 26, 26);
        write_alpha(16'($urandom));
        test_random(150, 0, 0);

        $display("%0d samples in %0d blocks, %0d levels checked", n_samples, n_blocks, n_checked);
        $display("alpha extremes, full-scale blocks, idle and stall phases, long hold-off");
        if (errors == 0 && level_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rlm_pkg.sv
rtl/core/rlm_in_if.sv
rtl/core/rlm_out_if.sv
rtl/core/rms_level_meter_db_top.sv
tb/tb.sv
